// File: design/median_window_tds_converter_top_defines.svh
// Assertion helpers shared by the converter RTL.
`ifndef MEDIAN_WINDOW_TDS_CONVERTER_TOP_DEFINES_SVH
`define MEDIAN_WINDOW_TDS_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication
`define MWTC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MWTC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mwtc_pkg.sv
package mwtc_pkg;

   typedef struct packed {
      logic        cmd;
      logic [11:0] sample;
   } req_type;

   typedef struct packed {
      logic [11:0] median_code;
      logic [18:0] comp_voltage_q16;
      logic [17:0] tds_tenths_ppm;
      logic        saturated;
   } rsp_type;

   typedef enum logic {
      CSR_WATER_TEMP = 1'b0,
      CSR_REF_MV     = 1'b1
   } csr_index_type;

   // per-cycle control shared by every window cell
   typedef struct packed {
      logic shift;   // push: take the previous cell's sample (the new sample in cell 0)
      logic load;    // start ranking: copy sample to rotating slot
      logic rotate;  // rank step: compare, count, pass rotating slot on
   } cell_ctl_type;

   localparam logic        CMD_PUSH     = 1'b0;
   localparam logic        CMD_EVAL     = 1'b1;
   localparam logic [18:0] VOLT_MAX     = 19'd524287;
   localparam logic [17:0] TDS_MAX      = 18'd262143;
   localparam logic [18:0] COEF_CUBE    = 19'd66710;
   localparam logic [18:0] COEF_SQUARE  = 19'd127930;
   localparam logic [18:0] COEF_LINEAR  = 19'd428695;
   localparam logic [45:0] TDS_ROUND    = 46'd3276800;
   localparam int          TDS_SHIFT    = 18;       // 6553600 = 25 << 18
   // x / 25 == (x * ceil(2^33 / 25)) >> 33 for any x below 2^28
   localparam logic [28:0] TDS_RECIP    = 29'd343597384;
   localparam int          TDS_RECIP_SHIFT = 33;
   localparam logic [9:0]  TEMP_OFFSET  = 10'd250;
   localparam logic [8:0]  TEMP_RESET   = 9'd250;
   localparam logic [12:0] REF_RESET    = 13'd3300;

endpackage

// File: design/mwtc_cell.sv
module mwtc_cell #(
   parameter int SB    = 12,
   parameter int CW    = 5,
   parameter int K_LO  = 14,
   parameter int K_HI  = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mwtc_pkg::cell_ctl_type ctl,
   input  logic [SB-1:0]         a_prev,
   input  logic [SB-1:0]         b_prev,
   output logic [SB-1:0]         a_out,
   output logic [SB-1:0]         b_out,
   output logic [SB-1:0]         lo_val,
   output logic [SB-1:0]         hi_val
);

   logic [SB-1:0] a_ff;
   logic [SB-1:0] b_ff;
   logic [CW-1:0] lt_ff;
   logic [CW-1:0] le_ff;
   logic          hit_lo;
   logic          hit_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
      end else if (ctl.shift) begin
         a_ff <= a_prev;
      end
   end

   // lt/le: entries strictly below / not above this sample
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         b_ff  <= a_ff;
         lt_ff <= '0;
         le_ff <= '0;
      end else if (ctl.rotate) begin
         b_ff  <= b_prev;
         lt_ff <= lt_ff + CW'(b_ff < a_ff);
         le_ff <= le_ff + CW'(b_ff <= a_ff);
      end
   end

   assign hit_lo = (lt_ff <= CW'(K_LO)) && (CW'(K_LO) < le_ff);
   assign hit_hi = (lt_ff <= CW'(K_HI)) && (CW'(K_HI) < le_ff);
   assign a_out  = a_ff;
   assign b_out  = b_ff;
   assign lo_val = hit_lo ? a_ff : '0;
   assign hi_val = hit_hi ? a_ff : '0;

endmodule

// File: design/mwtc_div.sv
module mwtc_div #(
   parameter int NUMW = 41,
   parameter int DENW = 23
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] num,
   input  logic [DENW-1:0] den,
   output logic            done,
   output logic [NUMW-1:0] quo
);

   localparam int CNTW = $clog2(NUMW + 1);

   logic [NUMW-1:0] quo_ff;
   logic [DENW-1:0] rem_ff;
   logic [DENW-1:0] den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            done_ff;
   logic [DENW:0]   trial;
   logic            fits;

   assign trial = {rem_ff, quo_ff[NUMW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNTW'(NUMW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? DENW'(trial - {1'b0, den_ff}) : DENW'(trial);
         quo_ff <= {quo_ff[NUMW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: design/median_window_tds_converter_top.sv
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_stall  mwtc_pkg::req_type (cmd, sample)
// rsp_      out  rsp_valid/rsp_stall  mwtc_pkg::rsp_type (one per evaluate)
// csr_      in   csr_valid/csr_ready  csr_index, csr_data (13 bits)
//
// A push shifts the window when taken; pushes may arrive back to back.
// An evaluate reaches rsp_valid after one rank pass around the cell chain, a bit-serial
// voltage divide, then the cubic on the shared multiplier and a reciprocal divide by 25.
// req_stall is high until the result enters the output register; it drops as rsp_valid rises.
// A held result stalls a later evaluate only at its output step; pushes are taken while idle.
// Synchronous active-high reset zeroes the window and loads register defaults.
`include "median_window_tds_converter_top_defines.svh"

module median_window_tds_converter_top #(
   parameter int WINDOW_LEN  = 30,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mwtc_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mwtc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  mwtc_pkg::csr_index_type csr_index,
   input  logic [12:0]             csr_data
);

   localparam int SB   = SAMPLE_BITS;
   localparam int CW   = $clog2(WINDOW_LEN + 1);
   localparam int K_LO = (WINDOW_LEN - 1) / 2;   // lower middle rank
   localparam int K_HI = WINDOW_LEN / 2;         // upper middle rank
   localparam int NUMW = SB + 29;                // (m*ref) << 16, plus rounding
   localparam int DENW = SB + 11;                // (temp+250) << (SB+1)

   typedef enum logic [15:0] {
      ST_IDLE = 16'b0000_0000_0000_0001,
      ST_LOAD = 16'b0000_0000_0000_0010,
      ST_RANK = 16'b0000_0000_0000_0100,
      ST_PICK = 16'b0000_0000_0000_1000,
      ST_MEAN = 16'b0000_0000_0001_0000,
      ST_VST  = 16'b0000_0000_0010_0000,
      ST_VWT  = 16'b0000_0000_0100_0000,
      ST_SQ   = 16'b0000_0000_1000_0000,
      ST_CU   = 16'b0000_0001_0000_0000,
      ST_T3   = 16'b0000_0010_0000_0000,
      ST_T2   = 16'b0000_0100_0000_0000,
      ST_T1   = 16'b0000_1000_0000_0000,
      ST_SUM  = 16'b0001_0000_0000_0000,
      ST_TST  = 16'b0010_0000_0000_0000,
      ST_TWT  = 16'b0100_0000_0000_0000,
      ST_OUT  = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // ---- configuration registers ----
   logic [8:0]  temp_ff;
   logic [12:0] ref_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= mwtc_pkg::TEMP_RESET;
         ref_ff  <= mwtc_pkg::REF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mwtc_pkg::CSR_WATER_TEMP: temp_ff <= csr_data[8:0];
            mwtc_pkg::CSR_REF_MV:     ref_ff  <= csr_data;
            default:                  ref_ff  <= ref_ff;
         endcase
      end
   end

   // ---- request handshake ----
   logic req_take;
   logic push;
   logic eval;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign push      = req_take && (req_data.cmd == mwtc_pkg::CMD_PUSH);
   assign eval      = req_take && (req_data.cmd == mwtc_pkg::CMD_EVAL);

   // ---- window cell chain ----
   // Push shifts the chain; the oldest sample falls off the end, so the
   // chain holds the same set as a ring buffer. Ranking circulates a copy
   // of every sample past every cell, one hop per cycle.
   mwtc_pkg::cell_ctl_type cell_ctl;
   logic [SB-1:0] a_chain [WINDOW_LEN];
   logic [SB-1:0] b_chain [WINDOW_LEN];
   logic [SB-1:0] lo_vals [WINDOW_LEN];
   logic [SB-1:0] hi_vals [WINDOW_LEN];
   logic [SB-1:0] new_sample;

   assign new_sample      = SB'(req_data.sample);
   assign cell_ctl.shift  = push;
   assign cell_ctl.load   = (state_ff == ST_LOAD);
   assign cell_ctl.rotate = (state_ff == ST_RANK);

   for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
      mwtc_cell #(
         .SB   (SB),
         .CW   (CW),
         .K_LO (K_LO),
         .K_HI (K_HI)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (cell_ctl),
         .a_prev ((g == 0) ? new_sample : a_chain[(g == 0) ? 0 : g - 1]),
         .b_prev (b_chain[(g == 0) ? WINDOW_LEN - 1 : g - 1]),
         .a_out  (a_chain[g]),
         .b_out  (b_chain[g]),
         .lo_val (lo_vals[g]),
         .hi_val (hi_vals[g])
      );
   end

   // cells that hit the same rank hold equal values, so OR selects it
   logic [SB-1:0] lo_or;
   logic [SB-1:0] hi_or;

   always_comb begin
      lo_or = '0;
      hi_or = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         lo_or = lo_or | lo_vals[i];
         hi_or = hi_or | hi_vals[i];
      end
   end

   logic [CW-1:0] rank_cnt_ff;
   logic [SB-1:0] x_lo_ff;
   logic [SB-1:0] x_hi_ff;
   logic [SB-1:0] med_ff;
   logic [SB:0]   mid_sum;

   assign mid_sum = {1'b0, x_lo_ff} + {1'b0, x_hi_ff};

   // ---- voltage divider ----
   logic [9:0]      temp_sum;
   logic [SB+12:0]  med_ref;
   logic [NUMW-1:0] div_num;
   logic [DENW-1:0] div_den;
   logic            div_start;
   logic            div_done;
   logic [NUMW-1:0] div_quo;

   assign temp_sum = {1'b0, temp_ff} + mwtc_pkg::TEMP_OFFSET;
   assign med_ref  = (SB+13)'(med_ff) * (SB+13)'(ref_ff);

   // ---- shared multiplier for the cubic ----
   logic [24:0] mul_a;
   logic [18:0] mul_b;
   logic [43:0] prod_ff;
   logic [21:0] v2_ff;
   logic [18:0] volt_ff;
   logic        vsat_ff;
   logic signed [45:0] acc_ff;
   logic [45:0] s_rnd;
   logic [27:0] tds_scaled;

   // ---- TDS / 25 by reciprocal multiply ----
   logic [27:0] scl_ff;
   logic [56:0] tds_prod;
   logic [23:0] tds_quo;
   logic [17:0] tds_ff;
   logic        tsat_ff;

   assign s_rnd      = (acc_ff[45] ? 46'd0 : 46'(acc_ff)) + mwtc_pkg::TDS_ROUND;
   assign tds_scaled = s_rnd[45:mwtc_pkg::TDS_SHIFT];
   assign tds_prod   = 57'(scl_ff) * 57'(mwtc_pkg::TDS_RECIP);
   assign tds_quo    = tds_prod[56:mwtc_pkg::TDS_RECIP_SHIFT];

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_VST: begin
            div_start = 1'b1;
            div_num   = {med_ref, 16'd0} + (NUMW'(temp_sum) << SB);
            div_den   = DENW'(temp_sum) << (SB + 1);
         end
         ST_SQ: begin
            mul_a = 25'(volt_ff);
            mul_b = volt_ff;
         end
         ST_CU: begin
            mul_a = 25'(prod_ff[37:16]);
            mul_b = volt_ff;
         end
         ST_T3: begin
            mul_a = prod_ff[40:16];
            mul_b = mwtc_pkg::COEF_CUBE;
         end
         ST_T2: begin
            mul_a = 25'(v2_ff);
            mul_b = mwtc_pkg::COEF_SQUARE;
         end
         ST_T1: begin
            mul_a = 25'(volt_ff);
            mul_b = mwtc_pkg::COEF_LINEAR;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   mwtc_div #(
      .NUMW (NUMW),
      .DENW (DENW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---- result register ----
   logic              rsp_valid_ff;
   mwtc_pkg::rsp_type rsp_ff;
   logic              rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (eval) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_RANK;
         ST_RANK: if (rank_cnt_ff == CW'(1)) state_in = ST_PICK;
         ST_PICK: state_in = ST_MEAN;
         ST_MEAN: state_in = ST_VST;
         ST_VST:  state_in = ST_VWT;
         ST_VWT:  if (div_done) state_in = ST_SQ;
         ST_SQ:   state_in = ST_CU;
         ST_CU:   state_in = ST_T3;
         ST_T3:   state_in = ST_T2;
         ST_T2:   state_in = ST_T1;
         ST_T1:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_TST;
         ST_TST:  state_in = ST_TWT;
         ST_TWT:  state_in = ST_OUT;
         ST_OUT:  if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         rank_cnt_ff <= CW'(WINDOW_LEN);
      end else if (state_ff == ST_RANK) begin
         rank_cnt_ff <= rank_cnt_ff - 1'b1;
      end
      if (state_ff == ST_PICK) begin
         x_lo_ff <= lo_or;
         x_hi_ff <= hi_or;
      end
      if (state_ff == ST_MEAN) begin
         med_ff <= mid_sum[SB:1];
      end
      if (state_ff == ST_VWT && div_done) begin
         vsat_ff <= div_quo > NUMW'(mwtc_pkg::VOLT_MAX);
         volt_ff <= (div_quo > NUMW'(mwtc_pkg::VOLT_MAX)) ? mwtc_pkg::VOLT_MAX
                                                           : div_quo[18:0];
      end
      prod_ff <= 44'(mul_a) * 44'(mul_b);
      if (state_ff == ST_CU) begin
         v2_ff <= prod_ff[37:16];
      end
      if (state_ff == ST_T2) begin
         acc_ff <= $signed({2'b00, prod_ff});
      end else if (state_ff == ST_T1) begin
         acc_ff <= acc_ff - $signed({2'b00, prod_ff});
      end else if (state_ff == ST_SUM) begin
         acc_ff <= acc_ff + $signed({2'b00, prod_ff});
      end
      if (state_ff == ST_TST) begin
         scl_ff <= tds_scaled;
      end
      if (state_ff == ST_TWT) begin
         if (tds_quo > 24'(mwtc_pkg::TDS_MAX)) begin
            tds_ff  <= mwtc_pkg::TDS_MAX;
            tsat_ff <= 1'b1;
         end else begin
            tds_ff  <= tds_quo[17:0];
            tsat_ff <= 1'b0;
         end
      end
      // load only when the previous result has left
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_ff.median_code      <= 12'(med_ff);
         rsp_ff.comp_voltage_q16 <= volt_ff;
         rsp_ff.tds_tenths_ppm   <= tds_ff;
         rsp_ff.saturated        <= vsat_ff || tsat_ff;
      end
   end

   // divider results only land while the sequencer waits on them
   `MWTC_ASSERT_IMP(a_div_done_wait, clock, reset, div_done, state_ff == ST_VWT, "divider done outside a wait state")
   // an accepted evaluate starts the rank pass next cycle
   `MWTC_ASSERT_NXT(a_eval_loads, clock, reset, eval, state_ff == ST_LOAD, "evaluate did not start ranking")
   // a new result only comes from the output step
   `MWTC_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT, "result raised outside output step")

endmodule
